>>> rtl/bitmap_block_allocator_next_fit_assert.svh
// Assertion macros for the next-fit block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define BBANF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked out of reset.
`define BBANF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBANF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define BBANF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

>>> rtl/bbanf_pkg.sv
// Shared constants, types and codes of the next-fit block allocator.
package bbanf_pkg;

	localparam int NUM_BLOCKS    = 1024;
	localparam int BLK_W         = 10;
	localparam int MAP_WORD_BITS = 32;
	localparam int BIT_W         = 5;
	localparam int MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
	localparam int WADDR_W       = 5;
	localparam int CNT_W         = 11;
	localparam int STEP_W        = 6;
	// Step index of the final pass over the first word (wrap-around part)
	localparam int LAST_STEP     = MAP_WORDS;
	localparam int OP_W          = 2;
	localparam int ST_W          = 2;
	localparam int S_TDATA_W     = 16;
	localparam int M_TDATA_W     = 24;
	localparam int M_PAD_W       = M_TDATA_W - CNT_W - BLK_W;

	typedef logic [BLK_W-1:0]         blk_t;
	typedef logic [MAP_WORD_BITS-1:0] word_t;
	typedef logic [WADDR_W-1:0]       waddr_t;
	typedef logic [BIT_W-1:0]         bitpos_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [STEP_W-1:0]        step_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BADFREE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_RESP
	} state_t;

	// Request to the allocation map store
	typedef struct packed {
		logic   rd_en;
		waddr_t rd_addr;
		logic   wr_en;
		waddr_t wr_addr;
		word_t  wr_data;
		logic   clr;
	} map_req_t;

	// One map word to be searched for a free, unreserved block
	typedef struct packed {
		word_t   data;
		waddr_t  addr;
		bitpos_t lo_bit;
		logic    hi_en;
		bitpos_t hi_bit;
		blk_t    reserved;
	} scan_req_t;

	typedef struct packed {
		logic    found;
		bitpos_t pos;
	} scan_rsp_t;

endpackage

>>> rtl/bitmap_block_allocator_next_fit.sv
// Top level of the next-fit bitmap block allocator.
//
// Keeps a 1024-block allocation map as 32 words of 32 bits in a single-port-read
// store, plus a free-block count. Blocks below reserved_blocks are never handed
// out; writing that register clears the map. Allocate searches from the block
// after the hint, wrapping round, one map word per cycle through one shared
// search unit: up to 33 word reads (the first word is visited again for the
// blocks below the hint). Free reads one word and, if the block was in use,
// writes it back with the block cleared; a free inside the reserved region,
// clear and the unused operation code read no word. One item is in work at a
// time; the input is ready again once the result has moved to the output
// register, and a stalled output holds it back.
// Reset and clear take effect at once, with no clearing pass over the store.
// s_axis_tdata holds block_index, s_axis_tuser holds operation; m_axis_tdata
// holds result_block then free_count, m_axis_tuser holds status.
`include "bitmap_block_allocator_next_fit_assert.svh"

module bitmap_block_allocator_next_fit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bbanf_pkg::BLK_W-1:0]     cfg_wr_data,     // reserved_blocks
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [bbanf_pkg::S_TDATA_W-1:0] s_axis_tdata,    // [9:0] block_index
	input  logic [bbanf_pkg::OP_W-1:0]      s_axis_tuser,    // [1:0] operation
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [bbanf_pkg::M_TDATA_W-1:0] m_axis_tdata,    // [9:0] result_block, [20:10] free_count
	output logic [bbanf_pkg::ST_W-1:0]      m_axis_tuser     // [1:0] status
);

	bbanf_pkg::state_t    state_q, state_d;
	bbanf_pkg::blk_t      res_q;
	bbanf_pkg::count_t    free_q;
	bbanf_pkg::waddr_t    w0_q;
	bbanf_pkg::bitpos_t   b0_q;
	bbanf_pkg::blk_t      idx_q;
	bbanf_pkg::step_t     issue_step_q;
	bbanf_pkg::step_t     chk_step_s1;
	logic                 chk_vld_s1;
	bbanf_pkg::blk_t      pend_blk_q;
	bbanf_pkg::status_t   pend_st_q;
	logic                 m_vld_q;
	bbanf_pkg::blk_t      out_blk_q;
	bbanf_pkg::status_t   out_st_q;
	bbanf_pkg::count_t    out_free_q;

	bbanf_pkg::map_req_t  map_req;
	bbanf_pkg::word_t     rd_data;
	bbanf_pkg::scan_req_t scan_req;
	bbanf_pkg::scan_rsp_t scan_rsp;

	logic                 accept;
	bbanf_pkg::op_t       op_in;
	bbanf_pkg::blk_t      in_blk;
	bbanf_pkg::blk_t      start_blk;
	bbanf_pkg::waddr_t    issue_word;
	bbanf_pkg::waddr_t    chk_word;
	logic                 issue_more;
	logic                 scan_hit;
	logic                 scan_miss;
	logic                 free_bit;
	logic                 out_free;

	bbanf_map_mem u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (map_req),
		.rd_data (rd_data)
	);

	bbanf_scan_unit u_scan (
		.req (scan_req),
		.rsp (scan_rsp)
	);

	// Decode the input item and the scan position
	always_comb begin
		s_axis_tready = (state_q == bbanf_pkg::S_IDLE);
		accept        = s_axis_tvalid && s_axis_tready;
		op_in         = bbanf_pkg::op_t'(s_axis_tuser);
		in_blk        = s_axis_tdata[bbanf_pkg::BLK_W-1:0];
		start_blk     = in_blk + bbanf_pkg::BLK_W'(1);
		issue_word    = w0_q + issue_step_q[bbanf_pkg::WADDR_W-1:0];
		chk_word      = w0_q + chk_step_s1[bbanf_pkg::WADDR_W-1:0];
		issue_more    = (issue_step_q <= bbanf_pkg::STEP_W'(bbanf_pkg::LAST_STEP));
		out_free      = !m_vld_q || m_axis_tready;
		free_bit      = rd_data[idx_q[bbanf_pkg::BIT_W-1:0]];

		scan_req.data     = rd_data;
		scan_req.addr     = chk_word;
		scan_req.lo_bit   = (chk_step_s1 == '0) ? b0_q : '0;
		scan_req.hi_en    = (chk_step_s1 == bbanf_pkg::STEP_W'(bbanf_pkg::LAST_STEP));
		scan_req.hi_bit   = b0_q;
		scan_req.reserved = res_q;

		scan_hit  = (state_q == bbanf_pkg::S_SCAN) && chk_vld_s1 && scan_rsp.found;
		scan_miss = (state_q == bbanf_pkg::S_SCAN) && chk_vld_s1 && !scan_rsp.found
			&& scan_req.hi_en;
	end

	// Sequence the map accesses and pick the next state
	always_comb begin
		state_d         = state_q;
		map_req         = '0;
		map_req.clr     = cfg_wr_en;
		unique case (state_q)
			bbanf_pkg::S_IDLE: begin
				if (accept) begin
					unique case (op_in)
						bbanf_pkg::OP_ALLOC: begin
							map_req.rd_en   = 1'b1;
							map_req.rd_addr = start_blk[bbanf_pkg::BLK_W-1:bbanf_pkg::BIT_W];
							state_d         = bbanf_pkg::S_SCAN;
						end
						bbanf_pkg::OP_FREE: begin
							if (in_blk < res_q) begin
								state_d = bbanf_pkg::S_RESP;
							end else begin
								map_req.rd_en   = 1'b1;
								map_req.rd_addr = in_blk[bbanf_pkg::BLK_W-1:bbanf_pkg::BIT_W];
								state_d         = bbanf_pkg::S_FREE_CHK;
							end
						end
						bbanf_pkg::OP_CLEAR: begin
							map_req.clr = 1'b1;
							state_d     = bbanf_pkg::S_RESP;
						end
						default: begin
							state_d = bbanf_pkg::S_RESP;
						end
					endcase
				end
			end
			bbanf_pkg::S_SCAN: begin
				if (issue_more) begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = issue_word;
				end
				if (scan_hit) begin
					map_req.wr_en   = 1'b1;
					map_req.wr_addr = chk_word;
					map_req.wr_data = rd_data | (bbanf_pkg::word_t'(1) << scan_rsp.pos);
					state_d         = bbanf_pkg::S_RESP;
				end else if (scan_miss) begin
					state_d = bbanf_pkg::S_RESP;
				end
			end
			bbanf_pkg::S_FREE_CHK: begin
				if (free_bit) begin
					map_req.wr_en   = 1'b1;
					map_req.wr_addr = idx_q[bbanf_pkg::BLK_W-1:bbanf_pkg::BIT_W];
					map_req.wr_data = rd_data
						& ~(bbanf_pkg::word_t'(1) << idx_q[bbanf_pkg::BIT_W-1:0]);
				end
				state_d = bbanf_pkg::S_RESP;
			end
			bbanf_pkg::S_RESP: begin
				if (out_free) begin
					state_d = bbanf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bbanf_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers: state, register, free count, scan steps, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bbanf_pkg::S_IDLE;
			res_q        <= '0;
			free_q       <= bbanf_pkg::count_t'(bbanf_pkg::NUM_BLOCKS);
			issue_step_q <= '0;
			chk_vld_s1   <= 1'b0;
			m_vld_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				res_q  <= cfg_wr_data;
				free_q <= bbanf_pkg::count_t'(bbanf_pkg::NUM_BLOCKS)
					- bbanf_pkg::count_t'(cfg_wr_data);
			end
			if (accept) begin
				issue_step_q <= bbanf_pkg::STEP_W'(1);
				chk_vld_s1   <= (op_in == bbanf_pkg::OP_ALLOC);
				if (op_in == bbanf_pkg::OP_CLEAR) begin
					free_q <= bbanf_pkg::count_t'(bbanf_pkg::NUM_BLOCKS)
						- bbanf_pkg::count_t'(res_q);
				end
			end
			if (state_q == bbanf_pkg::S_SCAN) begin
				chk_vld_s1 <= issue_more;
				if (issue_more) begin
					issue_step_q <= issue_step_q + bbanf_pkg::STEP_W'(1);
				end
			end
			if (scan_hit && (free_q != '0)) begin
				free_q <= free_q - bbanf_pkg::count_t'(1);
			end
			if ((state_q == bbanf_pkg::S_FREE_CHK) && free_bit) begin
				free_q <= free_q + bbanf_pkg::count_t'(1);
			end
			if ((state_q == bbanf_pkg::S_RESP) && out_free) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers: scan start, free target, pending and output result
	always_ff @(posedge clk) begin
		if (accept) begin
			w0_q       <= start_blk[bbanf_pkg::BLK_W-1:bbanf_pkg::BIT_W];
			b0_q       <= start_blk[bbanf_pkg::BIT_W-1:0];
			idx_q      <= in_blk;
			pend_blk_q <= '0;
			pend_st_q  <= ((op_in == bbanf_pkg::OP_FREE) && (in_blk < res_q))
				? bbanf_pkg::ST_BADFREE : bbanf_pkg::ST_OK;
		end
		if (state_q == bbanf_pkg::S_SCAN) begin
			chk_step_s1 <= issue_step_q;
		end else begin
			chk_step_s1 <= '0;
		end
		if (scan_hit) begin
			pend_blk_q <= {chk_word, scan_rsp.pos};
		end
		if (scan_miss) begin
			pend_st_q <= bbanf_pkg::ST_FULL;
		end
		if ((state_q == bbanf_pkg::S_FREE_CHK) && !free_bit) begin
			pend_st_q <= bbanf_pkg::ST_BADFREE;
		end
		if ((state_q == bbanf_pkg::S_RESP) && out_free) begin
			out_blk_q  <= pend_blk_q;
			out_st_q   <= pend_st_q;
			out_free_q <= free_q;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {{bbanf_pkg::M_PAD_W{1'b0}}, out_free_q, out_blk_q};
	assign m_axis_tuser  = out_st_q;

	// Free count never exceeds the unreserved blocks
	`BBANF_ASSERT_IMPL(a_free_bound, clk, arst_n, 1'b1, free_q <= (bbanf_pkg::count_t'(bbanf_pkg::NUM_BLOCKS) - bbanf_pkg::count_t'(res_q)), "free count above unreserved blocks")
	// A full report carries block zero and an empty count
	`BBANF_ASSERT_IMPL(a_full_result, clk, arst_n, m_vld_q && (out_st_q == bbanf_pkg::ST_FULL), (out_blk_q == '0) && (out_free_q == '0), "full report with blocks left")
	// Map writes only from the scan or free check
	`BBANF_ASSERT_IMPL(a_wr_state, clk, arst_n, map_req.wr_en, (state_q == bbanf_pkg::S_SCAN) || (state_q == bbanf_pkg::S_FREE_CHK), "map write outside scan or free")
	// Busy after taking an item
	`BBANF_ASSERT_NEXT(a_busy, clk, arst_n, accept, !s_axis_tready, "ready straight after accept")

endmodule

>>> rtl/bbanf_map_mem.sv
// Allocation map store: one word per row, registered read, per-row valid bits.
module bbanf_map_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  bbanf_pkg::map_req_t req,
	output bbanf_pkg::word_t    rd_data
);

	bbanf_pkg::word_t                   mem_q [bbanf_pkg::MAP_WORDS];
	logic [bbanf_pkg::MAP_WORDS-1:0]    row_vld_q;
	bbanf_pkg::word_t                   rd_word_q;
	logic                               rd_vld_q;

	// Write and read the word array
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem_q[req.rd_addr];
		end
	end

	// Track written rows; a clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (req.clr) begin
				row_vld_q <= '0;
			end else if (req.wr_en) begin
				row_vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= row_vld_q[req.rd_addr];
			end
		end
	end

	// An unwritten row reads as all free
	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

>>> rtl/bbanf_scan_unit.sv
// Shared word search: masks one map word and finds its lowest free data block.
module bbanf_scan_unit (
	input  bbanf_pkg::scan_req_t req,
	output bbanf_pkg::scan_rsp_t rsp
);

	logic [bbanf_pkg::MAP_WORD_BITS-1:0] elig;
	bbanf_pkg::waddr_t                   res_word;
	bbanf_pkg::bitpos_t                  res_bit;
	bbanf_pkg::bitpos_t                  bit_idx;

	// Mark free bits inside the window and above the reserved region
	always_comb begin
		res_word = req.reserved[bbanf_pkg::BLK_W-1:bbanf_pkg::BIT_W];
		res_bit  = req.reserved[bbanf_pkg::BIT_W-1:0];
		bit_idx  = '0;
		for (int i = 0; i < bbanf_pkg::MAP_WORD_BITS; i++) begin
			bit_idx = bbanf_pkg::BIT_W'(i);
			elig[i] = !req.data[i]
				&& (bit_idx >= req.lo_bit)
				&& (!req.hi_en || (bit_idx < req.hi_bit))
				&& ((req.addr > res_word) || ((req.addr == res_word) && (bit_idx >= res_bit)));
		end
	end

	// Pick the lowest eligible bit
	always_comb begin
		rsp.found = |elig;
		rsp.pos   = '0;
		for (int i = bbanf_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (elig[i]) begin
				rsp.pos = bbanf_pkg::BIT_W'(i);
			end
		end
	end

endmodule
